FILE: rtl/vass_pkg.sv
`default_nettype none
package vass_pkg;

   localparam int ANGLE_BITS    = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int TABLE_LEN     = 24;

   localparam int COORD_W  = 32;
   localparam int DIFF_W   = COORD_W + 1;
   localparam int NORM_MSB = 40;
   localparam int XW       = NORM_MSB + 4;
   localparam int SHIFT_W  = 6;
   localparam int MSB_W    = 6;
   localparam int ACC_W    = 32;
   localparam int SECT_W   = 3;
   localparam int FWD_W    = 16;
   localparam int DZ_W     = 16;
   localparam int LOG2_W   = 2;

   localparam int REQ_DATA_W = 4 * COORD_W;
   localparam int RSP_DATA_W = 8;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOG2      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FORWARD   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEAD_ZONE = 2'd3;

   localparam logic [LOG2_W-1:0] LOG2_EIGHT = 2'd3;

   localparam logic [ACC_W-1:0] HALF_TURN = 32'h8000_0000;

   typedef struct packed {
      logic valid;
      logic held;
      logic zero;
   } vass_ctl_type;

   typedef struct packed {
      logic              enable;
      logic [LOG2_W-1:0] log2;
      logic [FWD_W-1:0]  forward;
      logic [DZ_W-1:0]   dead_zone;
   } vass_cfg_type;

   // arctangent of 2^-i as a fraction of a full turn, 32-bit binary angle
   function automatic logic [ACC_W-1:0] atan_turn(input int i);
      logic [ACC_W-1:0] r;
      case (i)
         0:       r = 32'h2000_0000;
         1:       r = 32'h12E4_051E;
         2:       r = 32'h09FB_385B;
         3:       r = 32'h0511_11D4;
         4:       r = 32'h028B_0D43;
         5:       r = 32'h0145_D7E1;
         6:       r = 32'h00A2_F61E;
         7:       r = 32'h0051_7C55;
         8:       r = 32'h0028_BE53;
         9:       r = 32'h0014_5F2F;
         10:      r = 32'h000A_2F98;
         11:      r = 32'h0005_17CC;
         12:      r = 32'h0002_8BE6;
         13:      r = 32'h0001_45F3;
         14:      r = 32'h0000_A2FA;
         15:      r = 32'h0000_517D;
         16:      r = 32'h0000_28BE;
         17:      r = 32'h0000_145F;
         18:      r = 32'h0000_0A30;
         19:      r = 32'h0000_0518;
         20:      r = 32'h0000_028C;
         21:      r = 32'h0000_0146;
         22:      r = 32'h0000_00A3;
         23:      r = 32'h0000_0051;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/vass_prep.sv
`default_nettype none
module vass_prep (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               advance,
   input  wire logic                               in_valid,
   input  wire logic [vass_pkg::REQ_DATA_W-1:0]    in_data,
   input  wire vass_pkg::vass_cfg_type             cfg,
   output vass_pkg::vass_ctl_type                  out_ctl,
   output logic signed [vass_pkg::XW-1:0]          out_x,
   output logic signed [vass_pkg::XW-1:0]          out_y,
   output logic [vass_pkg::ACC_W-1:0]              out_acc
);
   import vass_pkg::*;

   // stage 1: differences
   vass_ctl_type             ctl1_ff, ctl1_in;
   logic signed [DIFF_W-1:0] dx1_ff, dx1_in, dz1_ff, dz1_in;
   // stage 2: magnitudes
   vass_ctl_type             ctl2_ff, ctl2_in;
   logic signed [DIFF_W-1:0] dx2_ff, dz2_ff;
   logic [DIFF_W-1:0]        ax2_ff, ax2_in, az2_ff, az2_in;
   // stage 3: dead zone and leading one
   vass_ctl_type             ctl3_ff, ctl3_in;
   logic signed [DIFF_W-1:0] dx3_ff, dz3_ff;
   logic [SHIFT_W-1:0]       sh3_ff, sh3_in;
   // stage 4: normalize and fold into the right half plane
   vass_ctl_type             ctl4_ff, ctl4_in;
   logic signed [XW-1:0]     x4_ff, x4_in, y4_ff, y4_in;
   logic [ACC_W-1:0]         acc4_ff, acc4_in;

   logic signed [COORD_W-1:0] vx, vz, sx, sz;
   logic [DIFF_W-1:0]         mor;
   logic [MSB_W-1:0]          msb;
   logic signed [XW-1:0]      xs, ys;

   assign vx = in_data[0*COORD_W +: COORD_W];
   assign vz = in_data[1*COORD_W +: COORD_W];
   assign sx = in_data[2*COORD_W +: COORD_W];
   assign sz = in_data[3*COORD_W +: COORD_W];

   always_comb begin
      ctl1_in = '{valid: in_valid, held: !cfg.enable, zero: 1'b0};
      dx1_in  = DIFF_W'(vx) - DIFF_W'(sx);
      dz1_in  = DIFF_W'(vz) - DIFF_W'(sz);
   end

   always_comb begin
      ctl2_in = ctl1_ff;
      ax2_in  = dx1_ff[DIFF_W-1] ? DIFF_W'(-dx1_ff) : DIFF_W'(dx1_ff);
      az2_in  = dz1_ff[DIFF_W-1] ? DIFF_W'(-dz1_ff) : DIFF_W'(dz1_ff);
   end

   always_comb begin
      mor = ax2_ff | az2_ff;
      msb = '0;
      for (int i = 0; i < DIFF_W; i++) begin
         if (mor[i]) msb = MSB_W'(i);
      end
      ctl3_in       = ctl2_ff;
      ctl3_in.held  = ctl2_ff.held
                      || ((ax2_ff < DIFF_W'(cfg.dead_zone)) && (az2_ff < DIFF_W'(cfg.dead_zone)));
      ctl3_in.zero  = (mor == '0);
      sh3_in        = SHIFT_W'(NORM_MSB) - SHIFT_W'(msb);
   end

   always_comb begin
      xs      = XW'(dz3_ff) <<< sh3_ff;
      ys      = XW'(dx3_ff) <<< sh3_ff;
      ctl4_in = ctl3_ff;
      if (xs[XW-1]) begin
         x4_in   = -xs;
         y4_in   = -ys;
         acc4_in = HALF_TURN;
      end else begin
         x4_in   = xs;
         y4_in   = ys;
         acc4_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff.valid <= 1'b0;
         ctl2_ff.valid <= 1'b0;
         ctl3_ff.valid <= 1'b0;
         ctl4_ff.valid <= 1'b0;
      end else if (advance) begin
         ctl1_ff <= ctl1_in;
         dx1_ff  <= dx1_in;
         dz1_ff  <= dz1_in;
         ctl2_ff <= ctl2_in;
         dx2_ff  <= dx1_ff;
         dz2_ff  <= dz1_ff;
         ax2_ff  <= ax2_in;
         az2_ff  <= az2_in;
         ctl3_ff <= ctl3_in;
         dx3_ff  <= dx2_ff;
         dz3_ff  <= dz2_ff;
         sh3_ff  <= sh3_in;
         ctl4_ff <= ctl4_in;
         x4_ff   <= x4_in;
         y4_ff   <= y4_in;
         acc4_ff <= acc4_in;
      end
   end

   assign out_ctl = ctl4_ff;
   assign out_x   = x4_ff;
   assign out_y   = y4_ff;
   assign out_acc = acc4_ff;

endmodule
`default_nettype wire

FILE: rtl/vass_cordic.sv
`default_nettype none
module vass_cordic (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               advance,
   input  wire vass_pkg::vass_ctl_type             in_ctl,
   input  wire logic signed [vass_pkg::XW-1:0]     in_x,
   input  wire logic signed [vass_pkg::XW-1:0]     in_y,
   input  wire logic [vass_pkg::ACC_W-1:0]         in_acc,
   output vass_pkg::vass_ctl_type                  out_ctl,
   output logic [vass_pkg::ACC_W-1:0]              out_acc
);
   import vass_pkg::*;

   // one vectoring iteration per register stage
   vass_ctl_type         ctl_ff [CORDIC_STAGES];
   logic signed [XW-1:0] x_ff   [CORDIC_STAGES];
   logic signed [XW-1:0] y_ff   [CORDIC_STAGES];
   logic [ACC_W-1:0]     acc_ff [CORDIC_STAGES];

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      vass_ctl_type         ctl_cur;
      logic signed [XW-1:0] x_cur, y_cur, x_in, y_in;
      logic [ACC_W-1:0]     acc_cur, acc_in;

      if (i == 0) begin : g_head
         assign ctl_cur = in_ctl;
         assign x_cur   = in_x;
         assign y_cur   = in_y;
         assign acc_cur = in_acc;
      end else begin : g_body
         assign ctl_cur = ctl_ff[i-1];
         assign x_cur   = x_ff[i-1];
         assign y_cur   = y_ff[i-1];
         assign acc_cur = acc_ff[i-1];
      end

      always_comb begin
         if (!y_cur[XW-1]) begin
            x_in   = x_cur + (y_cur >>> i);
            y_in   = y_cur - (x_cur >>> i);
            acc_in = acc_cur + atan_turn(i);
         end else begin
            x_in   = x_cur - (y_cur >>> i);
            y_in   = y_cur + (x_cur >>> i);
            acc_in = acc_cur - atan_turn(i);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[i].valid <= 1'b0;
         end else if (advance) begin
            ctl_ff[i] <= ctl_cur;
            x_ff[i]   <= x_in;
            y_ff[i]   <= y_in;
            acc_ff[i] <= acc_in;
         end
      end
   end

   assign out_ctl = ctl_ff[CORDIC_STAGES-1];
   assign out_acc = acc_ff[CORDIC_STAGES-1];

endmodule
`default_nettype wire

FILE: rtl/vass_sector.sv
`default_nettype none
module vass_sector (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               advance,
   input  wire vass_pkg::vass_ctl_type             in_ctl,
   input  wire logic [vass_pkg::ACC_W-1:0]         in_acc,
   input  wire vass_pkg::vass_cfg_type             cfg,
   output logic                                    out_valid,
   output logic [vass_pkg::SECT_W-1:0]             out_sector,
   output logic                                    out_held
);
   import vass_pkg::*;

   vass_ctl_type           ctl_ff, ctl_in;
   logic [ANGLE_BITS-1:0]  rel_ff, rel_in;
   logic                   valid_ff;
   logic [SECT_W-1:0]      sector_ff, sector_in;
   logic                   held_ff;

   logic [ACC_W-1:0]       acc_eff, acc_rnd, fwd32;
   logic [ANGLE_BITS-1:0]  theta, fwd, r4, r8;

   always_comb begin
      // a zero vector counts as angle zero
      acc_eff = in_ctl.zero ? '0 : in_acc;
      acc_rnd = acc_eff + (ACC_W'(1) << (ACC_W - 1 - ANGLE_BITS));
      theta   = acc_rnd[ACC_W-1 -: ANGLE_BITS];
      fwd32   = {cfg.forward, (ACC_W-FWD_W)'(0)};
      fwd     = fwd32[ACC_W-1 -: ANGLE_BITS];
      rel_in  = theta - fwd;
      ctl_in  = in_ctl;
   end

   always_comb begin
      // half a sector of rounding before taking the top bits
      r4 = rel_ff + (ANGLE_BITS'(1) << (ANGLE_BITS - 3));
      r8 = rel_ff + (ANGLE_BITS'(1) << (ANGLE_BITS - 4));
      if (ctl_ff.held) begin
         sector_in = '0;
      end else if (cfg.log2 == LOG2_EIGHT) begin
         sector_in = r8[ANGLE_BITS-1 -: 3];
      end else begin
         sector_in = {1'b0, r4[ANGLE_BITS-1 -: 2]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
         valid_ff     <= 1'b0;
      end else if (advance) begin
         ctl_ff    <= ctl_in;
         valid_ff  <= ctl_ff.valid;
         rel_ff    <= rel_in;
         sector_ff <= sector_in;
         held_ff   <= ctl_ff.held;
      end
   end

   assign out_valid  = valid_ff;
   assign out_sector = sector_ff;
   assign out_held   = held_ff;

endmodule
`default_nettype wire

FILE: rtl/view_angle_sector_select.sv
// channel   dir  handshake                  payload
// req       in   req_tvalid / req_tready    tdata: viewer_x, viewer_z, sprite_x, sprite_z
// rsp       out  rsp_tvalid / rsp_tready    tdata: sector; tuser: held
// csr       in   csr_we                     csr_index, csr_wdata
//
// one query per cycle while no result waits on rsp_tready; a result shows on rsp after
// 22 register stages, the first loading at the transfer: four setup stages,
// one stage per cordic iteration (16), one angle stage and the output register.
// reset clears only the valid bits, not the data registers; no clearing pass.
// one stall signal freezes every stage while a result waits on rsp_tready;
// req_tready follows it, so nothing is lost or repeated.
`default_nettype none
module view_angle_sector_select (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output logic                                        req_tready,
   // viewer_x, viewer_z, sprite_x, sprite_z
   input  wire logic [vass_pkg::REQ_DATA_W-1:0]        req_tdata,
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // sector
   output logic [vass_pkg::RSP_DATA_W-1:0]             rsp_tdata,
   // held
   output logic                                        rsp_tuser,
   input  wire logic                                   csr_we,
   input  wire logic [vass_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire logic [vass_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import vass_pkg::*;

   vass_cfg_type          cfg_ff;
   logic                  advance;
   vass_ctl_type          prep_ctl, cordic_ctl;
   logic signed [XW-1:0]  prep_x, prep_y;
   logic [ACC_W-1:0]      prep_acc, cordic_acc;
   logic [SECT_W-1:0]     sector;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable    <= 1'b0;
         cfg_ff.log2      <= LOG2_EIGHT;
         cfg_ff.forward   <= '0;
         cfg_ff.dead_zone <= DZ_W'(66);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ENABLE:    cfg_ff.enable    <= csr_wdata[0];
            CSR_LOG2:      cfg_ff.log2      <= csr_wdata[LOG2_W-1:0];
            CSR_FORWARD:   cfg_ff.forward   <= csr_wdata[FWD_W-1:0];
            CSR_DEAD_ZONE: cfg_ff.dead_zone <= csr_wdata[DZ_W-1:0];
            default: ;
         endcase
      end
   end

   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   vass_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_tvalid),
      .in_data  (req_tdata),
      .cfg      (cfg_ff),
      .out_ctl  (prep_ctl),
      .out_x    (prep_x),
      .out_y    (prep_y),
      .out_acc  (prep_acc)
   );

   vass_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_ctl  (prep_ctl),
      .in_x    (prep_x),
      .in_y    (prep_y),
      .in_acc  (prep_acc),
      .out_ctl (cordic_ctl),
      .out_acc (cordic_acc)
   );

   vass_sector u_sector (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_ctl     (cordic_ctl),
      .in_acc     (cordic_acc),
      .cfg        (cfg_ff),
      .out_valid  (rsp_tvalid),
      .out_sector (sector),
      .out_held   (rsp_tuser)
   );

   assign rsp_tdata = {(RSP_DATA_W-SECT_W)'(0), sector};

endmodule
`default_nettype wire

FILE: rtl/vass_checker.sv
`default_nettype none
module vass_checker (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   input  wire logic                                   req_tready,
   input  wire logic [vass_pkg::REQ_DATA_W-1:0]        req_tdata,
   input  wire logic                                   rsp_tvalid,
   input  wire logic                                   rsp_tready,
   input  wire logic [vass_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  wire logic                                   rsp_tuser,
   input  wire logic                                   csr_we,
   input  wire logic [vass_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire logic [vass_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import vass_pkg::*;

   // a held result always carries sector zero
   a_held_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("held result with nonzero sector");

   // sector never exceeds three bits
   a_sector_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:SECT_W] == '0)
      else $error("sector out of range");

   // the input is open whenever the output register is free
   a_ready_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid || rsp_tready |-> req_tready)
      else $error("input stalled with free output");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // query and register write payloads are known whenever they are offered
   a_inputs_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown({req_tvalid, csr_we})
      && (!req_tvalid || !$isunknown(req_tdata))
      && (!csr_we || !$isunknown({csr_index, csr_wdata})))
      else $error("unknown value on an input");

endmodule

bind view_angle_sector_select vass_checker u_vass_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .csr_we     (csr_we),
   .csr_index  (csr_index),
   .csr_wdata  (csr_wdata)
);
`default_nettype wire

FILE: test/sector_select_checker.sv
`timescale 1ns / 100ps
// watches the query, result and register ports, predicts each sector and compares
module sector_select_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   input  wire logic                                req_tready,
   // viewer_x, viewer_z, sprite_x, sprite_z
   input  wire logic [vass_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // sector
   input  wire logic [vass_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // held
   input  wire logic                                rsp_tuser,
   input  wire logic                                csr_we,
   input  wire logic [vass_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [vass_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int unsigned                              fail_count,
   output int unsigned                              pending_count,
   output int unsigned                              results_checked,
   output int unsigned                              held_seen
);
   import vass_pkg::*;

   typedef struct {
      int unsigned       query;
      logic [SECT_W-1:0] sector;
      logic              held;
   } sector_expect_type;

   // arctangent of 2^-i in 32-bit turns
   logic [ACC_W-1:0]  turn_step [TABLE_LEN];
   vass_cfg_type      settings;
   sector_expect_type expected_sectors [$];
   int unsigned       accepted_queries;

   initial begin
      turn_step = '{
         32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
         32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
         32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
         32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
         32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
         32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051};
      fail_count       = 0;
      pending_count    = 0;
      results_checked  = 0;
      held_seen        = 0;
      accepted_queries = 0;
   end

   function automatic longint magnitude(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic sector_expect_type predict_sector(input logic [REQ_DATA_W-1:0] q,
                                                        input int unsigned n);
      sector_expect_type     r;
      longint                dx, dz, x, y, t, m, zone;
      logic [ACC_W-1:0]      acc, rounded, fwd_turn;
      logic [ANGLE_BITS-1:0] theta, fwd, rel;
      int                    k;
      r.query  = n;
      r.sector = '0;
      r.held   = 1'b1;
      dx   = longint'($signed(q[31:0])) - longint'($signed(q[95:64]));
      dz   = longint'($signed(q[63:32])) - longint'($signed(q[127:96]));
      zone = longint'(settings.dead_zone);
      if (!settings.enable || (magnitude(dx) < zone && magnitude(dz) < zone))
         return r;

      // vectoring cordic on (dz, dx), angle measured from +z toward +x
      acc = '0;
      x   = dz;
      y   = dx;
      if (x != 0 || y != 0) begin
         m = (magnitude(x) > magnitude(y)) ? magnitude(x) : magnitude(y);
         while (m < (longint'(1) << NORM_MSB)) begin
            m = m * 2;
            x = x * 2;
            y = y * 2;
         end
         if (x < 0) begin
            x   = -x;
            y   = -y;
            acc = HALF_TURN;
         end
         for (int i = 0; i < CORDIC_STAGES && i < TABLE_LEN; i++) begin
            if (y >= 0) begin
               t   = x + (y >>> i);
               y   = y - (x >>> i);
               x   = t;
               acc = acc + turn_step[i];
            end else begin
               t   = x - (y >>> i);
               y   = y + (x >>> i);
               x   = t;
               acc = acc - turn_step[i];
            end
         end
      end

      rounded  = acc + (32'd1 << (31 - ANGLE_BITS));
      theta    = rounded[ACC_W-1 -: ANGLE_BITS];
      fwd_turn = {settings.forward, 16'd0};
      fwd      = fwd_turn[ACC_W-1 -: ANGLE_BITS];
      // fewer than four sectors is not supported, clamp up
      k        = (settings.log2 < 2) ? 2 : int'(settings.log2);
      rel      = theta - fwd + (ANGLE_BITS'(1) << (ANGLE_BITS - k - 1));
      r.sector = SECT_W'(rel >> (ANGLE_BITS - k));
      r.held   = 1'b0;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      fail_count++;
   endtask

   always @(posedge clock) begin : watch
      sector_expect_type want;
      if (reset) begin
         settings.enable    = 1'b0;
         settings.log2      = LOG2_EIGHT;
         settings.forward   = '0;
         settings.dead_zone = 16'd66;
         expected_sectors.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_sectors.size() == 0) begin
               report_mismatch("result transfer with no query outstanding");
            end else begin
               want = expected_sectors.pop_front();
               if (rsp_tdata !== RSP_DATA_W'(want.sector))
                  report_mismatch($sformatf("query %0d: sector got %0d expected %0d",
                                            want.query, rsp_tdata, want.sector));
               if (rsp_tuser !== want.held)
                  report_mismatch($sformatf("query %0d: held got %b expected %b",
                                            want.query, rsp_tuser, want.held));
               results_checked++;
               if (want.held)
                  held_seen++;
            end
         end
         if (req_tvalid && req_tready) begin
            expected_sectors.push_back(predict_sector(req_tdata, accepted_queries));
            accepted_queries++;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_ENABLE:    settings.enable    = csr_wdata[0];
               CSR_LOG2:      settings.log2      = csr_wdata[LOG2_W-1:0];
               CSR_FORWARD:   settings.forward   = csr_wdata[FWD_W-1:0];
               CSR_DEAD_ZONE: settings.dead_zone = csr_wdata[DZ_W-1:0];
               default: ;
            endcase
         end
      end
      pending_count = expected_sectors.size();
   end

endmodule

FILE: test/view_angle_sector_select_tb.sv
`timescale 1ns / 100ps
module view_angle_sector_select_tb;
   import vass_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int TAIL_CYCLES = 40;
   localparam logic [LOG2_W-1:0] LOG2_FOUR = 2'd2;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = CSR_ENABLE;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   int unsigned fail_count, pending_count, results_checked, held_seen;
   int unsigned queries_sent      = 0;
   int unsigned settings_used     = 0;
   int unsigned sender_idle_pct   = 13;
   int unsigned receiver_idle_pct = 51;
   int unsigned cycle_count       = 0;
   logic [DZ_W-1:0] cur_dead_zone = 16'd66;

   view_angle_sector_select dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   sector_select_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .results_checked (results_checked),
      .held_seen       (held_seen)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
   end

   // writes all four registers back to back; upper data bits are noise
   task automatic set_config(input logic en, input logic [LOG2_W-1:0] log2,
                             input logic [FWD_W-1:0] fwd, input logic [DZ_W-1:0] dz);
      csr_we    <= 1'b1;
      csr_index <= CSR_ENABLE;
      csr_wdata <= (CSR_DATA_W'($urandom) & ~CSR_DATA_W'(1)) | CSR_DATA_W'(en);
      @(posedge clock);
      csr_index <= CSR_LOG2;
      csr_wdata <= (CSR_DATA_W'($urandom) & ~CSR_DATA_W'(3)) | CSR_DATA_W'(log2);
      @(posedge clock);
      csr_index <= CSR_FORWARD;
      csr_wdata <= fwd;
      @(posedge clock);
      csr_index <= CSR_DEAD_ZONE;
      csr_wdata <= dz;
      @(posedge clock);
      csr_we        <= 1'b0;
      cur_dead_zone  = dz;
      settings_used++;
   endtask

   task automatic send_query(input logic [31:0] vx, input logic [31:0] vz,
                             input logic [31:0] sx, input logic [31:0] sz);
      if (queries_sent < 183) begin
         sender_idle_pct   = 13;
         receiver_idle_pct = 51;
      end else if (queries_sent < 366) begin
         sender_idle_pct   = 51;
         receiver_idle_pct = 13;
      end else begin
         sender_idle_pct   = 0;
         receiver_idle_pct = 0;
      end
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {sz, sx, vz, vx};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      queries_sent++;
   endtask

   function automatic logic [31:0] pick_extreme();
      case ($urandom_range(0, 4))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random_query();
      logic [31:0] vx, vz, sx, sz;
      int          ox, oz, span;
      sx   = $urandom;
      sz   = $urandom;
      vx   = $urandom;
      vz   = $urandom;
      span = int'(cur_dead_zone) + 2;
      ox   = int'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
      oz   = int'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000;
      case ($urandom_range(0, 9))
         0, 1, 2: ;
         3, 4: begin
            // straddle the dead zone edges
            vx = sx + (int'($urandom_range(0, 2 * span)) - span);
            vz = sz + (int'($urandom_range(0, 2 * span)) - span);
         end
         5: begin
            vx = sx;
            vz = sz;
            if ($urandom_range(0, 1))
               vx = sx + ox;
            else
               vz = sz + ox;
         end
         6: begin
            vx = sx + ox;
            vz = $urandom_range(0, 1) ? sz + ox : sz - ox;
         end
         7: begin
            vx = sx + ox;
            vz = sz + oz;
         end
         8: begin
            vx = pick_extreme();
            vz = pick_extreme();
            sx = pick_extreme();
            sz = pick_extreme();
         end
         default: begin
            vx = sx + (int'($urandom_range(0, 8192)) - 4096);
            vz = sz + (int'($urandom_range(0, 8192)) - 4096);
         end
      endcase
      send_query(vx, vz, sx, sz);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
   endtask

   task automatic run_random(input logic en, input logic [LOG2_W-1:0] log2,
                             input logic [FWD_W-1:0] fwd, input logic [DZ_W-1:0] dz,
                             input int n);
      wait_idle();
      set_config(en, log2, fwd, dz);
      repeat (n) send_random_query();
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // out of reset the block is disabled, so everything is held
      send_query(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0);
      send_query(32'h0, 32'h0001_0000, 32'h0, 32'h0);

      wait_idle();
      set_config(1'b1, LOG2_EIGHT, 16'h0000, 16'd66);
      // largest differences in all four quadrants
      send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      send_query(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      send_query(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      // the four axis directions
      send_query(32'h0, 32'h0001_0000, 32'h0, 32'h0);
      send_query(32'h0001_0000, 32'h0, 32'h0, 32'h0);
      send_query(32'h0, -32'sh0001_0000, 32'h0, 32'h0);
      send_query(-32'sh0001_0000, 32'h0, 32'h0, 32'h0);
      // dead zone edges: strictly inside on both axes is held
      send_query(32'd65, -32'sd65, 32'h0, 32'h0);
      send_query(32'd66, 32'h0, 32'h0, 32'h0);
      send_query(-32'sd65, -32'sd66, 32'h0, 32'h0);
      send_query(32'h1000_0000 - 32'd66, 32'h1000_0000 + 32'd66, 32'h1000_0000, 32'h1000_0000);
      send_query(32'h0004_0000, 32'h0004_0000, 32'h0, 32'h0);
      send_query(32'd67, 32'd1, 32'h0, 32'h0);

      wait_idle();
      set_config(1'b1, LOG2_FOUR, 16'hFFFF, 16'd0);
      // no dead zone: a zero vector takes angle zero
      send_query(32'h0, 32'h0, 32'h0, 32'h0);
      send_query(32'h1234_5678, 32'h8765_4321, 32'h1234_5678, 32'h8765_4321);
      send_query(32'd1, 32'h0, 32'h0, 32'h0);
      send_query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);

      wait_idle();
      // log2 below two acts as four sectors
      set_config(1'b1, 2'd0, 16'h8000, 16'hFFFF);
      send_query(32'h0000_FFFF, 32'h0, 32'h0, 32'h0);
      send_query(32'h0000_FFFE, -32'sh0000_FFFE, 32'h0, 32'h0);
      send_query(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);

      wait_idle();
      set_config(1'b1, 2'd1, 16'h2000, 16'h0100);
      send_query(32'h0, 32'h0000_0101, 32'h0, 32'h0);
      send_query(-32'sh0000_0200, 32'h0000_0100, 32'h0, 32'h0);

      run_random(1'b1, LOG2_EIGHT, FWD_W'($urandom), 16'd66, 80);
      run_random(1'b1, LOG2_FOUR, 16'hFFFF, 16'hFFFF, 80);
      run_random(1'b1, 2'd0, 16'h0000, 16'h0000, 80);
      run_random(1'b0, LOG2_EIGHT, FWD_W'($urandom), DZ_W'($urandom), 40);
      run_random(1'b1, 2'd1, 16'h8000, DZ_W'($urandom), 80);
      run_random(1'b1, LOG2_EIGHT, FWD_W'($urandom), DZ_W'($urandom_range(0, 512)), 80);
      run_random(1'b1, LOG2_FOUR, FWD_W'($urandom), 16'd66, 80);

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d queries under %0d register settings", queries_sent, settings_used);
      $display("compared %0d results, %0d of them held", results_checked, held_seen);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
